// ===== rtl/can_mailbox_filter_controller_top_macros.svh =====
// Assertion macros for the mailbox controller
`ifndef CAN_MAILBOX_FILTER_CONTROLLER_TOP_MACROS_SVH
`define CAN_MAILBOX_FILTER_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTH
`define CMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CMF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cmf_pkg;
	localparam int NUM_BOXES = 16;
	localparam int IDX_W = 4;
	localparam int ID_W = 29;
	localparam logic [ID_W-1:0] STD_FORCE = 29'h1ffff800;
	localparam logic [ID_W-1:0] ID_ALL = 29'h1fffffff;
	localparam logic [ID_W-1:0] EXT_BITS = 29'h1ffff800;
	// filter entry: valid, inbound, mask, filter
	localparam int FLT_W = 1 + 1 + ID_W + ID_W;
	// frame entry: payload, length, id
	localparam int FRM_W = 64 + 4 + ID_W;

	localparam logic [2:0] MODE_REG_STD = 3'd0;
	localparam logic [2:0] MODE_REG_EXT = 3'd1;
	localparam logic [2:0] MODE_SEND = 3'd2;
	localparam logic [2:0] MODE_RECV = 3'd3;
	localparam logic [2:0] MODE_BUS = 3'd4;
	localparam logic [2:0] MODE_RST_REQ = 3'd5;
	localparam logic [2:0] MODE_POLL = 3'd6;
	localparam logic [2:0] MODE_READ = 3'd7;

	localparam logic [1:0] BUS_ACTIVE = 2'd1;
	localparam logic [1:0] BUS_LISTENING = 2'd2;
	localparam logic [1:0] BUS_OFF = 2'd3;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) m[b*8 +: 8] = 8'hff;
		end
		return m;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/cmf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/can_mailbox_filter_controller_top.sv =====
// Operation: bus, restart and poll modes go straight to the result register; a read
// first issues a frame memory read; a registration does a frame read-modify-write to clear
// the stored length; send and receive scan the filter memory, one read per mailbox, then do
// a frame read-modify-write on a hit, or go to the result register when no mailbox matches.
// Items are handled one at a time; the next is taken once the result register is free.
// Reset: arst_n clears control state, bus active; a sweep then marks all filter entries
// invalid (reset filter) and frame entries zero before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none
module can_mailbox_filter_controller_top
	import cmf_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// mode[2:0], mailbox_index[6:3], inbound_flag[7], id_filter[36:8],
	// id_mask[65:37], frame_id[94:66], frame_length[98:95], frame_bytes[162:99],
	// new_bus_state[164:163], read_limit[168:165], zero fill to 176
	input  wire logic [175:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// accepted[0], hit_index[4:1], restart_pending[5], current_bus_state[7:6],
	// read_id[36:8], read_is_standard[37], read_length[41:38],
	// read_bytes[105:42], zero fill to 112
	output logic [111:0]      m_tdata
);
`include "can_mailbox_filter_controller_top_macros.svh"

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FRD, ST_FWR, ST_RD, ST_OUT}
		state_t;
	state_t state_q;

	logic [2:0] mode_q;
	logic [IDX_W-1:0] idx_q;
	logic inb_q;
	logic [ID_W-1:0] filt_q, mask_q, fid_q;
	logic [3:0] flen_q, limit_q;
	logic [63:0] fbytes_q;
	logic [1:0] bus_q;
	logic rreq_q;
	logic [IDX_W:0] cnt_q;
	logic [IDX_W-1:0] hit_q;
	logic pend_q, acc_q;

	logic flt_we, frm_we;
	logic [IDX_W-1:0] flt_waddr, flt_raddr, frm_addr;
	logic [FLT_W-1:0] flt_wdata, flt_rdata;
	logic [FRM_W-1:0] frm_wdata, frm_rdata;

	cmf_ram #(.WIDTH(FLT_W), .DEPTH(NUM_BOXES)) u_flt (
		.clk(clk), .we(flt_we), .waddr(flt_waddr), .wdata(flt_wdata),
		.raddr(flt_raddr), .rdata(flt_rdata));
	cmf_ram #(.WIDTH(FRM_W), .DEPTH(NUM_BOXES)) u_frm (
		.clk(clk), .we(frm_we), .waddr(frm_addr), .wdata(frm_wdata),
		.raddr(frm_addr), .rdata(frm_rdata));

	// decode filter entry read in scan; entry of an unregistered box reads as reset
	logic e_valid, e_inb;
	logic [ID_W-1:0] e_mask, e_filt;
	assign {e_valid, e_inb, e_mask, e_filt} = flt_rdata;
	logic e_match;
	assign e_match = ((e_valid ? e_inb : 1'b0) == (mode_q == MODE_RECV)) &&
		((((e_valid ? e_filt : '0) ^ fid_q) & (e_valid ? e_mask : ID_ALL)) == '0);

	logic [IDX_W-1:0] scan_idx;
	assign scan_idx = cnt_q[IDX_W-1:0] - 1'b1;

	// frame entry fields
	logic [63:0] r_pay;
	logic [3:0] r_len;
	logic [ID_W-1:0] r_id;
	assign {r_pay, r_len, r_id} = frm_rdata;
	logic [3:0] sat_len, rd_n;
	assign sat_len = (flen_q > 4'd8) ? 4'd8 : flen_q;
	assign rd_n = (limit_q < r_len) ? limit_q : r_len;

	logic is_reg;
	assign is_reg = (mode_q == MODE_REG_STD || mode_q == MODE_REG_EXT);

	// memory control
	always_comb begin
		flt_we = 1'b0;
		flt_waddr = idx_q;
		flt_wdata = {1'b1, inb_q, (mode_q == MODE_REG_STD) ? (mask_q | STD_FORCE) : mask_q,
			filt_q};
		flt_raddr = cnt_q[IDX_W-1:0];
		frm_we = 1'b0;
		frm_addr = (state_q == ST_FRD || state_q == ST_FWR) ? hit_q : idx_q;
		// registration keeps id and payload and clears the length
		frm_wdata = is_reg ? {r_pay, 4'd0, r_id} :
			{(r_pay & ~byte_mask(sat_len)) | (fbytes_q & byte_mask(sat_len)),
			sat_len, fid_q};
		case (state_q)
			ST_CLEAR: begin
				flt_we = 1'b1;
				flt_waddr = cnt_q[IDX_W-1:0];
				flt_wdata = '0;
				frm_we = 1'b1;
				frm_addr = cnt_q[IDX_W-1:0];
				frm_wdata = '0;
			end
			ST_FWR: begin
				frm_we = 1'b1;
				flt_we = is_reg;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			bus_q <= BUS_ACTIVE;
			rreq_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (IDX_W+1)'(NUM_BOXES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					// latch the item
					mode_q <= s_tdata[2:0];
					idx_q <= s_tdata[6:3];
					inb_q <= s_tdata[7];
					filt_q <= s_tdata[36:8];
					mask_q <= s_tdata[65:37];
					fid_q <= s_tdata[94:66];
					flen_q <= s_tdata[98:95];
					fbytes_q <= s_tdata[162:99];
					limit_q <= s_tdata[168:165];
					acc_q <= 1'b0;
					pend_q <= 1'b0;
					hit_q <= s_tdata[6:3];
					m_tdata <= '0;
					cnt_q <= '0;
					case (s_tdata[2:0])
						MODE_REG_STD, MODE_REG_EXT: state_q <= ST_FRD;
						MODE_SEND: state_q <= (bus_q == BUS_ACTIVE) ? ST_SCAN : ST_OUT;
						MODE_RECV: state_q <= (bus_q == BUS_ACTIVE || bus_q == BUS_LISTENING) ?
							ST_SCAN : ST_OUT;
						MODE_BUS: begin
							state_q <= ST_OUT;
							bus_q <= s_tdata[164:163];
							if (s_tdata[164:163] == BUS_OFF) rreq_q <= 1'b0;
						end
						MODE_RST_REQ: begin
							state_q <= ST_OUT;
							rreq_q <= 1'b1;
						end
						MODE_POLL: begin
							state_q <= ST_OUT;
							pend_q <= rreq_q;
							rreq_q <= 1'b0;
						end
						MODE_READ: state_q <= ST_RD;
						default: state_q <= ST_OUT;
					endcase
				end
				ST_SCAN: begin
					// address cnt_q issued; data of cnt_q-1 present when cnt_q > 0
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0 && e_match) begin
						hit_q <= scan_idx;
						state_q <= ST_FRD;
					end else if (cnt_q == (IDX_W+1)'(NUM_BOXES)) state_q <= ST_OUT;
				end
				ST_FRD: state_q <= ST_FWR;
				ST_FWR: begin
					acc_q <= (mode_q == MODE_SEND || mode_q == MODE_RECV);
					state_q <= ST_OUT;
				end
				ST_RD: begin
					// frame read of idx_q is issued in this cycle
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						m_tdata[0] <= acc_q;
						m_tdata[4:1] <= acc_q ? hit_q : '0;
						m_tdata[5] <= pend_q;
						m_tdata[7:6] <= bus_q;
						if (mode_q == MODE_READ) begin
							m_tdata[36:8] <= r_id;
							m_tdata[37] <= (r_id & EXT_BITS) == '0;
							m_tdata[41:38] <= r_len;
							m_tdata[105:42] <= r_pay & byte_mask(rd_n);
						end
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CMF_ASSERT_IMPL(a_ready_idle, clk, arst_n, s_tready, !m_tvalid)
	`CMF_ASSERT_IMPL(a_hit_acc, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[4:1] == '0)
	`CMF_ASSERT_NEXT(a_wr_from_rd, clk, arst_n, state_q == ST_FRD, state_q == ST_FWR)
endmodule
`default_nettype wire
